FILE: hw/rtl/vfv_pkg.sv
`default_nettype none
package vfv_pkg;

   // Default geometry of one chunk and width of a stored block type
   localparam int CHUNK_WIDTH_DEF  = 16;
   localparam int CHUNK_HEIGHT_DEF = 64;
   localparam int TYPE_BITS_DEF    = 4;

   // Request operation codes
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_PROBE = 1'b1;

   // Configuration register indexes
   localparam logic CSR_CHUNK_X = 1'b0;
   localparam logic CSR_CHUNK_Z = 1'b1;

   // Block type that goes to the second list
   localparam int SECOND_LIST_TYPE = 3;

endpackage
`default_nettype wire

FILE: hw/rtl/vfv_store.sv
`default_nettype none
module vfv_store #(
   parameter int DEPTH = 16384,
   parameter int AW    = 14,
   parameter int DW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] addr,
   input  wire logic [DW-1:0] wr_data,
   output logic      [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   // Single port: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end else if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/voxel_face_visibility_core.sv
`default_nettype none
// Hidden-face culling for one voxel chunk.
// Request channel (req_valid / req_stall): req_op selects a voxel write or a
// probe of the voxel at req_local_x/y/z. A write stores req_voxel_type in the
// chunk store in the cycle it is accepted; the next request may follow in the
// next cycle. A probe reads the voxel and its six neighbors one after another
// through the single store port (one read per cycle, neighbors on the chunk
// edge are skipped but still take their slot), so a probe holds req_stall high
// through 8 read/evaluate steps plus one decision step, which waits while the
// output register is held; no new request is taken until the probe is through.
// The result is written into the output register as the decision step ends.
// Response channel (rsp_valid / rsp_stall): one response for a probe of a
// solid voxel with at least one exposed face, none otherwise, and never for
// a write. The output register holds while rsp_stall is high; the core keeps
// taking writes meanwhile, and a finished probe waits in its decision step
// until the register frees up.
// Configuration (csr_*): chunk_x and chunk_z, to be written by the user only
// while idle; the core has no check for it. Reset clears control state and both
// chunk registers; store contents stay undefined until written, with no clearing pass.
module voxel_face_visibility_core #(
   parameter int CHUNK_WIDTH  = vfv_pkg::CHUNK_WIDTH_DEF,
   parameter int CHUNK_HEIGHT = vfv_pkg::CHUNK_HEIGHT_DEF,
   parameter int TYPE_BITS    = vfv_pkg::TYPE_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // configuration
   input  wire logic               csr_write,
   input  wire logic               csr_index,
   input  wire logic        [7:0]  csr_wdata,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_op,
   input  wire logic        [3:0]  req_local_x,
   input  wire logic        [5:0]  req_local_y,
   input  wire logic        [3:0]  req_local_z,
   input  wire logic        [3:0]  req_voxel_type,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [5:0]  rsp_face_mask,
   output logic signed      [11:0] rsp_world_x,
   output logic             [5:0]  rsp_world_y,
   output logic signed      [11:0] rsp_world_z,
   output logic             [3:0]  rsp_solid_type,
   output logic                    rsp_second_list
);

   localparam int DEPTH = CHUNK_WIDTH * CHUNK_HEIGHT * CHUNK_WIDTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = 11;   // holds any coordinate up to the largest chunk

   localparam logic [CW-1:0] W_C      = CW'(CHUNK_WIDTH);
   localparam logic [CW-1:0] H_C      = CW'(CHUNK_HEIGHT);
   localparam logic [CW-1:0] W_LAST   = CW'(CHUNK_WIDTH - 1);
   localparam logic [CW-1:0] H_LAST   = CW'(CHUNK_HEIGHT - 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   // read steps: center, then -x, -y, -z, +x, +y, +z, then the last evaluation
   localparam logic [2:0] STEP_CENTER = 3'd0;
   localparam logic [2:0] STEP_XN     = 3'd1;
   localparam logic [2:0] STEP_YN     = 3'd2;
   localparam logic [2:0] STEP_ZN     = 3'd3;
   localparam logic [2:0] STEP_XP     = 3'd4;
   localparam logic [2:0] STEP_YP     = 3'd5;
   localparam logic [2:0] STEP_ZP     = 3'd6;
   localparam logic [2:0] STEP_LAST   = 3'd7;

   logic [1:0]           state_ff, state_in;
   logic [2:0]           step_ff, step_in;
   logic [CW-1:0]        x_ff, y_ff, z_ff;
   logic [5:0]           mask_ff, mask_in;
   logic [TYPE_BITS-1:0] center_ff;
   logic signed [7:0]    chunk_x_ff, chunk_z_ff;

   logic                 rsp_valid_ff;
   logic [5:0]           rsp_mask_ff;
   logic [11:0]          rsp_wx_ff, rsp_wz_ff;
   logic [5:0]           rsp_wy_ff;
   logic [3:0]           rsp_type_ff;
   logic                 rsp_second_ff;

   logic                 req_accept;
   logic                 req_in_range;
   logic [CW-1:0]        ax, ay, az;
   logic [AW-1:0]        addr;
   logic                 mem_wr, mem_rd;
   logic [TYPE_BITS-1:0] mem_rdata;
   logic [5:0]           edge_hit;
   logic [2:0]           face;
   logic                 face_open;
   logic                 out_free;
   logic                 emit;
   logic [31:0]          wx_full, wz_full;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign req_in_range = (CW'(req_local_x) < W_C) && (CW'(req_local_y) < H_C)
                         && (CW'(req_local_z) < W_C);

   // faces on the chunk boundary are exposed without a store read
   assign edge_hit[0] = (x_ff == '0);
   assign edge_hit[1] = (y_ff == '0);
   assign edge_hit[2] = (z_ff == '0);
   assign edge_hit[3] = (x_ff == W_LAST);
   assign edge_hit[4] = (y_ff == H_LAST);
   assign edge_hit[5] = (z_ff == W_LAST);

   // shared address unit: pick the coordinate triple for this step
   always_comb begin
      ax = x_ff;
      ay = y_ff;
      az = z_ff;
      if (state_ff == S_IDLE) begin
         ax = CW'(req_local_x);
         ay = CW'(req_local_y);
         az = CW'(req_local_z);
      end else begin
         unique case (step_ff)
            STEP_XN: ax = x_ff - CW'(1);
            STEP_YN: ay = y_ff - CW'(1);
            STEP_ZN: az = z_ff - CW'(1);
            STEP_XP: ax = x_ff + CW'(1);
            STEP_YP: ay = y_ff + CW'(1);
            STEP_ZP: az = z_ff + CW'(1);
            default: ;
         endcase
      end
   end

   assign addr = AW'((AW'(ax) * AW'(CHUNK_HEIGHT) + AW'(ay)) * AW'(CHUNK_WIDTH) + AW'(az));

   assign mem_wr = req_accept && (req_op == vfv_pkg::OP_WRITE) && req_in_range;
   // skip the read where the neighbor lies past the chunk edge
   assign mem_rd = (state_ff == S_READ) && (step_ff != STEP_LAST)
                   && ((step_ff == STEP_CENTER) || !edge_hit[step_ff - 3'd1]);

   vfv_store #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (TYPE_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr),
      .rd_en   (mem_rd),
      .addr    (addr),
      .wr_data (TYPE_BITS'(req_voxel_type)),
      .rd_data (mem_rdata)
   );

   // evaluate the data read in the previous step
   assign face      = step_ff - 3'd2;
   assign face_open = edge_hit[face] || (mem_rdata == '0);

   always_comb begin
      mask_in = mask_ff;
      if ((state_ff == S_READ) && (step_ff >= STEP_YN)) begin
         mask_in = mask_ff | (6'(face_open) << face);
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = (state_ff == S_DONE) && (center_ff != '0) && (mask_ff != '0);

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            step_in = STEP_CENTER;
            if (req_accept && (req_op == vfv_pkg::OP_PROBE) && req_in_range) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            step_in = step_ff + 3'd1;
            if (step_ff == STEP_LAST) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // hold a result until the output register frees up
            if (!emit || out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         step_ff    <= STEP_CENTER;
         chunk_x_ff <= '0;
         chunk_z_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (csr_write) begin
            unique case (csr_index)
               vfv_pkg::CSR_CHUNK_X: chunk_x_ff <= csr_wdata;
               vfv_pkg::CSR_CHUNK_Z: chunk_z_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // probe payload: coordinates, center type and face mask
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE) begin
         x_ff    <= CW'(req_local_x);
         y_ff    <= CW'(req_local_y);
         z_ff    <= CW'(req_local_z);
         mask_ff <= '0;
      end else begin
         mask_ff <= mask_in;
      end
      if ((state_ff == S_READ) && (step_ff == STEP_XN)) begin
         center_ff <= mem_rdata;
      end
   end

   assign wx_full = 32'(chunk_x_ff) * 32'(CHUNK_WIDTH) + 32'(x_ff);
   assign wz_full = 32'(chunk_z_ff) * 32'(CHUNK_WIDTH) + 32'(z_ff);

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && out_free) begin
         rsp_mask_ff   <= mask_ff;
         rsp_wx_ff     <= wx_full[11:0];
         rsp_wy_ff     <= y_ff[5:0];
         rsp_wz_ff     <= wz_full[11:0];
         rsp_type_ff   <= 4'(center_ff);
         rsp_second_ff <= (32'(center_ff) == 32'(vfv_pkg::SECOND_LIST_TYPE));
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_face_mask   = rsp_mask_ff;
   assign rsp_world_x     = rsp_wx_ff;
   assign rsp_world_y     = rsp_wy_ff;
   assign rsp_world_z     = rsp_wz_ff;
   assign rsp_solid_type  = rsp_type_ff;
   assign rsp_second_list = rsp_second_ff;

endmodule
`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 100ps

localparam int CHUNK_W    = vfv_pkg::CHUNK_WIDTH_DEF;
localparam int CHUNK_H    = vfv_pkg::CHUNK_HEIGHT_DEF;
localparam int CELL_COUNT = CHUNK_W * CHUNK_H * CHUNK_W;

typedef struct packed {
   logic [5:0]         face_mask;
   logic signed [11:0] world_x;
   logic [5:0]         world_y;
   logic signed [11:0] world_z;
   logic [3:0]         solid_type;
   logic               second_list;
} face_rec_type;

// x-major, then y, then z
function automatic int voxel_slot(int x, int y, int z);
   return (x * CHUNK_H + y) * CHUNK_W + z;
endfunction

class face_scoreboard_type;
   bit [3:0]        chunk_cells [CELL_COUNT];
   bit signed [7:0] chunk_x;
   bit signed [7:0] chunk_z;
   face_rec_type    expected_faces [$];
   int              errors;

   function void set_chunk(logic index, logic [7:0] value);
      if (index == vfv_pkg::CSR_CHUNK_X) begin
         chunk_x = value;
      end else begin
         chunk_z = value;
      end
   endfunction

   function bit [3:0] cell_at(int x, int y, int z);
      return chunk_cells[voxel_slot(x, y, z)];
   endfunction

   function int pending();
      return expected_faces.size();
   endfunction

   // Update the store on a write; on a probe queue the face record it yields, if any.
   function void note_request(logic op, logic [3:0] x, logic [5:0] y, logic [3:0] z,
                              logic [3:0] vt);
      face_rec_type rec;
      bit [3:0]     kind;
      bit [5:0]     mask;
      int           ix, iy, iz, wx, wz;
      ix = int'(x);
      iy = int'(y);
      iz = int'(z);
      if (op == vfv_pkg::OP_WRITE) begin
         chunk_cells[voxel_slot(ix, iy, iz)] = vt;
         return;
      end
      kind = cell_at(ix, iy, iz);
      if (kind == 0) return;
      mask[0] = (ix == 0)           || (cell_at(ix - 1, iy, iz) == 0);
      mask[1] = (iy == 0)           || (cell_at(ix, iy - 1, iz) == 0);
      mask[2] = (iz == 0)           || (cell_at(ix, iy, iz - 1) == 0);
      mask[3] = (ix == CHUNK_W - 1) || (cell_at(ix + 1, iy, iz) == 0);
      mask[4] = (iy == CHUNK_H - 1) || (cell_at(ix, iy + 1, iz) == 0);
      mask[5] = (iz == CHUNK_W - 1) || (cell_at(ix, iy, iz + 1) == 0);
      if (mask == 0) return;
      wx = int'(chunk_x) * CHUNK_W + ix;
      wz = int'(chunk_z) * CHUNK_W + iz;
      rec.face_mask   = mask;
      rec.world_x     = wx[11:0];
      rec.world_y     = y;
      rec.world_z     = wz[11:0];
      rec.solid_type  = kind;
      rec.second_list = (int'(kind) == vfv_pkg::SECOND_LIST_TYPE);
      expected_faces = {expected_faces, rec};
   endfunction

   function void compare_field(string name, logic [11:0] want, logic [11:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      end
   endfunction

   function void check_face(face_rec_type got);
      face_rec_type want;
      if (expected_faces.size() == 0) begin
         errors++;
         $display("%0t: face record mismatch: expected none, got %h", $time, got);
         return;
      end
      want = expected_faces.pop_front();
      compare_field("face_mask", 12'(want.face_mask), 12'(got.face_mask));
      compare_field("world_x", want.world_x, got.world_x);
      compare_field("world_y", 12'(want.world_y), 12'(got.world_y));
      compare_field("world_z", want.world_z, got.world_z);
      compare_field("solid_type", 12'(want.solid_type), 12'(got.solid_type));
      compare_field("second_list", 12'(want.second_list), 12'(got.second_list));
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT   = 400000;
   // lets a probe with no record run out after the last expected record is back
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 445;
   localparam logic [3:0] TYPE_SECOND = 4'(vfv_pkg::SECOND_LIST_TYPE);

   logic               clock          = 1'b0;
   logic               reset          = 1'b1;
   logic               csr_write      = 1'b0;
   logic               csr_index      = 1'b0;
   logic        [7:0]  csr_wdata      = 8'h00;
   logic               req_valid      = 1'b0;
   logic               req_stall;
   logic               req_op         = vfv_pkg::OP_WRITE;
   logic        [3:0]  req_local_x    = 4'h0;
   logic        [5:0]  req_local_y    = 6'h00;
   logic        [3:0]  req_local_z    = 4'h0;
   logic        [3:0]  req_voxel_type = 4'h0;
   logic               rsp_valid;
   logic               rsp_stall      = 1'b0;
   logic        [5:0]  rsp_face_mask;
   logic signed [11:0] rsp_world_x;
   logic        [5:0]  rsp_world_y;
   logic signed [11:0] rsp_world_z;
   logic        [3:0]  rsp_solid_type;
   logic               rsp_second_list;

   face_scoreboard_type sb = new();
   face_rec_type        seen_face;
   bit                  written_map [CELL_COUNT];
   int                  snd_idle_pct = 26;
   int                  rcv_idle_pct = 45;
   int                  cycle_count  = 0;

   voxel_face_visibility_core i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_local_x    (req_local_x),
      .req_local_y    (req_local_y),
      .req_local_z    (req_local_z),
      .req_voxel_type (req_voxel_type),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_face_mask  (rsp_face_mask),
      .rsp_world_x    (rsp_world_x),
      .rsp_world_y    (rsp_world_y),
      .rsp_world_z    (rsp_world_z),
      .rsp_solid_type (rsp_solid_type),
      .rsp_second_list(rsp_second_list)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Hard stop in case a handshake never completes.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Response side: stall at random, changing only on the falling edge.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
   end

   // Capture each accepted face record and hand it to the scoreboard.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen_face.face_mask   = rsp_face_mask;
         seen_face.world_x     = rsp_world_x;
         seen_face.world_y     = rsp_world_y;
         seen_face.world_z     = rsp_world_z;
         seen_face.solid_type  = rsp_solid_type;
         seen_face.second_list = rsp_second_list;
         sb.check_face(seen_face);
      end
   end

   // Write one chunk register; the core must be idle.
   task automatic write_register(logic index, logic [7:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      sb.set_chunk(index, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic program_chunk(logic [7:0] cx, logic [7:0] cz);
      write_register(vfv_pkg::CSR_CHUNK_X, cx);
      write_register(vfv_pkg::CSR_CHUNK_Z, cz);
   endtask

   // Drive one request, with random idle cycles ahead of it, and hold it until accepted.
   // Returns right after the accepting rising edge.
   task automatic send_request(logic op, logic [3:0] x, logic [5:0] y, logic [3:0] z,
                               logic [3:0] vt);
      @(negedge clock);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_local_x    <= x;
      req_local_y    <= y;
      req_local_z    <= z;
      req_voxel_type <= vt;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, x, y, z, vt);
      if (op == vfv_pkg::OP_WRITE) begin
         written_map[voxel_slot(int'(x), int'(y), int'(z))] = 1'b1;
      end
   endtask

   // Drop valid, wait until every expected face record is back, then let a
   // probe with no record run out.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // A probe may only touch written cells: the voxel and every in-chunk neighbor.
   function automatic bit probe_ready(int x, int y, int z);
      if (!written_map[voxel_slot(x, y, z)]) return 1'b0;
      if (x > 0 && !written_map[voxel_slot(x - 1, y, z)]) return 1'b0;
      if (y > 0 && !written_map[voxel_slot(x, y - 1, z)]) return 1'b0;
      if (z > 0 && !written_map[voxel_slot(x, y, z - 1)]) return 1'b0;
      if (x < CHUNK_W - 1 && !written_map[voxel_slot(x + 1, y, z)]) return 1'b0;
      if (y < CHUNK_H - 1 && !written_map[voxel_slot(x, y + 1, z)]) return 1'b0;
      if (z < CHUNK_W - 1 && !written_map[voxel_slot(x, y, z + 1)]) return 1'b0;
      return 1'b1;
   endfunction

   // Favor the chunk walls so edge faces and extreme coordinates come up often.
   function automatic int edge_biased(int hi);
      int r;
      r = $urandom_range(9);
      if (r < 3) return 0;
      if (r < 6) return hi;
      return $urandom_range(hi);
   endfunction

   // Plenty of empty cells so faces open up, and type 3 for the second list.
   function automatic logic [3:0] pick_type();
      int r;
      r = $urandom_range(99);
      if (r < 30) return 4'd0;
      if (r < 45) return TYPE_SECOND;
      return 4'($urandom_range(15));
   endfunction

   // Corners, a fully buried voxel and an empty voxel.
   task automatic run_directed();
      // low corner: three walls plus an empty cell above
      send_request(vfv_pkg::OP_WRITE, 4'd0, 6'd0, 4'd0, 4'd15);
      send_request(vfv_pkg::OP_WRITE, 4'd1, 6'd0, 4'd0, TYPE_SECOND);
      send_request(vfv_pkg::OP_WRITE, 4'd0, 6'd1, 4'd0, 4'd0);
      send_request(vfv_pkg::OP_WRITE, 4'd0, 6'd0, 4'd1, 4'd5);
      send_request(vfv_pkg::OP_PROBE, 4'd0, 6'd0, 4'd0, 4'd15);
      // high corner, type 3, empty cell toward -z
      send_request(vfv_pkg::OP_WRITE, 4'd15, 6'd63, 4'd15, TYPE_SECOND);
      send_request(vfv_pkg::OP_WRITE, 4'd14, 6'd63, 4'd15, 4'd7);
      send_request(vfv_pkg::OP_WRITE, 4'd15, 6'd62, 4'd15, 4'd9);
      send_request(vfv_pkg::OP_WRITE, 4'd15, 6'd63, 4'd14, 4'd0);
      send_request(vfv_pkg::OP_PROBE, 4'd15, 6'd63, 4'd15, 4'd0);
      // buried voxel: all six neighbors solid, no record
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd32, 4'd8, 4'd2);
      send_request(vfv_pkg::OP_WRITE, 4'd7, 6'd32, 4'd8, 4'd1);
      send_request(vfv_pkg::OP_WRITE, 4'd9, 6'd32, 4'd8, 4'd4);
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd31, 4'd8, 4'd6);
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd33, 4'd8, 4'd8);
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd32, 4'd7, 4'd10);
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd32, 4'd9, 4'd12);
      send_request(vfv_pkg::OP_PROBE, 4'd8, 6'd32, 4'd8, 4'd3);
      // same voxel cleared: empty, no record
      send_request(vfv_pkg::OP_WRITE, 4'd8, 6'd32, 4'd8, 4'd0);
      send_request(vfv_pkg::OP_PROBE, 4'd8, 6'd32, 4'd8, 4'd9);
   endtask

   // Fill a 3x3x3 box with random types, then alternate a few rewrites, an odd
   // write anywhere in the chunk, and probes of cells that are safe to read.
   task automatic run_random(int quota);
      int sent, burst, ax, ay, az, slot, pick;
      int candidates [$];
      sent  = 0;
      burst = 0;
      while (sent < quota) begin
         // hold off until the pipeline is empty now and then
         if (burst == 2 || $urandom_range(9) == 0) settle();
         ax = edge_biased(CHUNK_W - 3);
         ay = edge_biased(CHUNK_H - 3);
         az = edge_biased(CHUNK_W - 3);
         for (int dx = 0; dx < 3; dx++) begin
            for (int dy = 0; dy < 3; dy++) begin
               for (int dz = 0; dz < 3; dz++) begin
                  send_request(vfv_pkg::OP_WRITE, 4'(ax + dx), 6'(ay + dy), 4'(az + dz),
                               pick_type());
                  sent++;
               end
            end
         end
         repeat (3) begin
            repeat ($urandom_range(1, 4)) begin
               send_request(vfv_pkg::OP_WRITE, 4'(ax + $urandom_range(2)),
                            6'(ay + $urandom_range(2)), 4'(az + $urandom_range(2)),
                            pick_type());
               sent++;
            end
            if ($urandom_range(1) == 1) begin
               send_request(vfv_pkg::OP_WRITE, 4'($urandom_range(15)), 6'($urandom_range(63)),
                            4'($urandom_range(15)), 4'($urandom_range(15)));
               sent++;
            end
            // gather probe targets in and around the box
            candidates.delete();
            for (int x = (ax > 0 ? ax - 1 : 0); x <= ax + 3 && x < CHUNK_W; x++) begin
               for (int y = (ay > 0 ? ay - 1 : 0); y <= ay + 3 && y < CHUNK_H; y++) begin
                  for (int z = (az > 0 ? az - 1 : 0); z <= az + 3 && z < CHUNK_W; z++) begin
                     if (probe_ready(x, y, z)) candidates = {candidates, voxel_slot(x, y, z)};
                  end
               end
            end
            repeat ($urandom_range(2, 6)) begin
               if (candidates.size() != 0) begin
                  pick = $urandom_range(candidates.size() - 1);
                  slot = candidates[pick];
                  send_request(vfv_pkg::OP_PROBE, 4'(slot / (CHUNK_W * CHUNK_H)),
                               6'((slot / CHUNK_W) % CHUNK_H), 4'(slot % CHUNK_W),
                               4'($urandom_range(15)));
                  sent++;
               end
            end
         end
         burst++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // phase 1: sender idles lightly, receiver stalls often
      snd_idle_pct = 26;
      rcv_idle_pct = 45;
      program_chunk(8'h80, 8'h7F);
      run_directed();
      settle();
      program_chunk(8'h7F, 8'h80);
      run_random(PHASE_ITEMS);
      settle();

      // phase 2: the other way round, random chunk position
      snd_idle_pct = 45;
      rcv_idle_pct = 26;
      program_chunk(8'($urandom_range(255)), 8'($urandom_range(255)));
      run_random(PHASE_ITEMS);
      settle();

      // phase 3: full rate on both sides, chunk back at the origin
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      program_chunk(8'h00, 8'h00);
      run_random(PHASE_ITEMS);
      settle();

      if (sb.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

FILE: voxel_face_visibility_core.f
hw/rtl/vfv_pkg.sv
hw/rtl/vfv_store.sv
hw/rtl/voxel_face_visibility_core.sv
sim/tb.sv
